### rtl/core/scte_pkg.sv
// Shared types, widths and elaboration-time helpers for the spin-coupled
// triple index expander: queue entry layout, coefficient codes, binomial tables.
// No dependencies.
`default_nettype none

package scte_pkg;

    localparam int ORB_W       = 5;
    localparam int IDX_W       = 14;
    localparam int COEF_W      = 16;
    localparam int CFG_W       = 6;
    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;
    localparam int TAB_AW      = 7;
    localparam int TAB_DEPTH   = 1 << TAB_AW;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // coefficient magnitude codes, sign travels separately
    typedef enum logic [2:0] {
        MAG_ZERO,
        MAG_ONE,
        MAG_HALF,
        MAG_H3,
        MAG_H2,
        MAG_H6
    } t_mag;

    typedef struct packed {
        logic             two_terms;
        logic             term_valid;
        logic [IDX_W-1:0] idx0;
        t_mag             mag0;
        logic             neg0;
        logic [IDX_W-1:0] idx1;
        t_mag             mag1;
        logic             neg1;
    } t_qent;

    typedef logic [IDX_W-1:0] t_tab [0:TAB_DEPTH-1];

    function automatic t_tab build_c2();
        t_tab tab;
        for (int i = 0; i < TAB_DEPTH; i++) begin
            tab[i] = (i < 2) ? '0 : IDX_W'((i * (i - 1)) / 2);
        end
        return tab;
    endfunction

    function automatic t_tab build_c3();
        t_tab tab;
        for (int i = 0; i < TAB_DEPTH; i++) begin
            tab[i] = (i < 3) ? '0 : IDX_W'((i * (i - 1) * (i - 2)) / 6);
        end
        return tab;
    endfunction

    localparam t_tab C2_TAB = build_c2();
    localparam t_tab C3_TAB = build_c3();

    // rounded integer square root, evaluated at elaboration only
    function automatic logic [63:0] isqrt_round(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (x > r) begin
            r = r + 64'd1;
        end
        return r;
    endfunction

    function automatic logic [COEF_W-1:0] sat_coef(input logic [63:0] mag, input logic neg);
        logic signed [64:0] v;
        v = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        if (v > 65'sd32767) begin
            return 16'h7fff;
        end else if (v < -65'sd32768) begin
            return 16'h8000;
        end
        return v[COEF_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/core/spin_coupled_triple_index_expander_top.sv
// Top level of the spin-coupled triple index expander: configuration register,
// front end, queue and term emitter. Uses scte_pkg, scte_front, scte_queue, scte_back.
`default_nettype none

// Each accepted item (spin block, pair spin, three orbitals) expands into one
// or two terms of packed basis index and Q-format coefficient; terms of one item
// leave back to back, the final one with tlast. The single output register
// emits one term per cycle while the sink is ready; the input takes an item
// every cycle while the four-entry queue between the classifier and the
// emitter has room. An item passes through the classifier register, the queue
// and the output register before its first term is presented. Illegal states
// or orbitals at or above the configured count give one term with tuser low,
// index and coefficient zero. Write the orbital count only while idle.
module spin_coupled_triple_index_expander_top #(
    parameter int MAX_SPATIAL_ORBITALS = 32,
    parameter int COEF_FRACTION_BITS   = 14
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [scte_pkg::CFG_W-1:0]  i_cfg_wr_data,   // spatial_orbitals
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    // [4:0] orbital_first, [9:5] orbital_second, [14:10] orbital_third, [15] zero
    input  wire logic [15:0]                 i_s_tdata,
    // [0] spin_block, [1] pair_spin
    input  wire logic [1:0]                  i_s_tuser,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    // [13:0] basis_index, [29:14] coefficient, [31:30] zero
    output logic [31:0]                      o_m_tdata,
    // [0] term_valid
    output logic                             o_m_tuser,
    output logic                             o_m_tlast
);

    localparam int NW = $clog2(MAX_SPATIAL_ORBITALS + 1);

    logic [scte_pkg::CFG_W-1:0]   r_spatial_orbitals;
    logic [NW-1:0]                n_orb;
    logic                         q_push, q_pop, q_full, q_empty;
    scte_pkg::t_qent              q_in, q_head;
    logic [scte_pkg::IDX_W-1:0]   out_index;
    logic [scte_pkg::COEF_W-1:0]  out_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spatial_orbitals <= scte_pkg::CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_spatial_orbitals <= i_cfg_wr_data;
        end
    end

    // clamp the orbital count to what the block is built for
    assign n_orb = (32'(r_spatial_orbitals) > 32'(MAX_SPATIAL_ORBITALS))
                 ? NW'(MAX_SPATIAL_ORBITALS) : NW'(r_spatial_orbitals);

    scte_front #(
        .MAX_SPATIAL_ORBITALS(MAX_SPATIAL_ORBITALS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_n              (n_orb),
        .i_valid          (i_s_tvalid),
        .o_ready          (o_s_tready),
        .i_spin_block     (i_s_tuser[0]),
        .i_pair_spin      (i_s_tuser[1]),
        .i_orbital_first  (i_s_tdata[4:0]),
        .i_orbital_second (i_s_tdata[9:5]),
        .i_orbital_third  (i_s_tdata[14:10]),
        .i_full           (q_full),
        .o_push           (q_push),
        .o_entry          (q_in)
    );

    scte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    scte_back #(
        .COEF_FRACTION_BITS(COEF_FRACTION_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_empty      (q_empty),
        .o_pop        (q_pop),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_term_valid (o_m_tuser),
        .o_index      (out_index),
        .o_coef       (out_coef),
        .o_last       (o_m_tlast)
    );

    assign o_m_tdata = {2'b00, out_coef, out_index};

    // an invalid state is always a lone, all-zero term
    a_invalid_lone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tlast && o_m_tdata == '0))
        else $error("invalid term not last or not zero");

    // the second term of an expansion follows right after the first
    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=> o_m_tvalid)
        else $error("second term did not follow");

    // only valid states expand into two terms
    a_pair_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> o_m_tuser)
        else $error("non-final term marked invalid");

endmodule

`default_nettype wire

### rtl/core/scte_front.sv
// Front end: accepts items, classifies the orbital ordering into term recipes,
// then resolves packed indices and pushes one queue entry per item. Uses scte_pkg.
`default_nettype none

module scte_front #(
    parameter int MAX_SPATIAL_ORBITALS = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [$clog2(MAX_SPATIAL_ORBITALS+1)-1:0] i_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic                              i_spin_block,
    input  wire logic                              i_pair_spin,
    input  wire logic [scte_pkg::ORB_W-1:0]        i_orbital_first,
    input  wire logic [scte_pkg::ORB_W-1:0]        i_orbital_second,
    input  wire logic [scte_pkg::ORB_W-1:0]        i_orbital_third,
    input  wire logic                              i_full,
    output logic                                   o_push,
    output scte_pkg::t_qent                        o_entry
);

    localparam int NW = $clog2(MAX_SPATIAL_ORBITALS + 1);
    localparam int CW = (NW > scte_pkg::ORB_W) ? NW : scte_pkg::ORB_W;
    localparam int PW = scte_pkg::ORB_W + NW;
    localparam int QW = 2 * NW;
    localparam int OW = scte_pkg::ORB_W;
    localparam int XW = scte_pkg::IDX_W;
    localparam int TW = scte_pkg::TAB_AW;

    typedef enum logic [1:0] {
        OFF_NONE,
        OFF_P,
        OFF_PT
    } t_off;

    typedef struct packed {
        logic            term_valid;
        logic            two_terms;
        logic            pair0;
        t_off            off0;
        logic [OW-1:0]   x;
        logic [OW-1:0]   y;
        logic [OW-1:0]   z;
        logic [OW-1:0]   px;
        logic [OW-1:0]   py;
        scte_pkg::t_mag  mag0;
        logic            neg0;
        scte_pkg::t_mag  mag1;
        logic            neg1;
    } t_cls;

    t_cls          r_cls;
    t_cls          n_cls;
    logic          r_v1;
    logic [XW-1:0] r_pcount;
    logic [XW-1:0] r_ptcount;
    logic [XW-1:0] n_pcount;
    logic [XW-1:0] n_ptcount;

    logic [OW-1:0] a, b, c, mn, mx;
    logic          gt_ab, gt_bc, gt_ac, pn, inval;

    assign a = i_orbital_first;
    assign b = i_orbital_second;
    assign c = i_orbital_third;
    assign gt_ab = a > b;
    assign gt_bc = b > c;
    assign gt_ac = a > c;
    assign mn = gt_ab ? b : a;
    assign mx = gt_ab ? a : b;
    assign pn = gt_ab && i_pair_spin;

    assign inval = (CW'(a) >= CW'(i_n)) || (CW'(b) >= CW'(i_n)) || (CW'(c) >= CW'(i_n))
                || (a == b && b == c)
                || (!i_spin_block && a == b && i_pair_spin)
                || (i_spin_block && (!i_pair_spin || a == b || b == c || a == c));

    always_comb begin
        n_cls = '0;
        n_cls.term_valid = 1'b1;
        n_cls.off0 = OFF_NONE;
        n_cls.mag0 = scte_pkg::MAG_ONE;
        n_cls.mag1 = scte_pkg::MAG_ONE;
        if (!i_spin_block) begin
            priority if (a == b) begin
                n_cls.pair0 = 1'b1;
                n_cls.px = a;
                n_cls.py = c;
            end else if (a < b && b < c) begin
                n_cls.x = a;
                n_cls.y = b;
                n_cls.z = c;
                n_cls.off0 = i_pair_spin ? OFF_PT : OFF_P;
            end else if (gt_ab && c > mx) begin
                n_cls.x = b;
                n_cls.y = a;
                n_cls.z = c;
                n_cls.off0 = i_pair_spin ? OFF_PT : OFF_P;
                n_cls.neg0 = pn;
            end else if (c < mn) begin
                n_cls.two_terms = 1'b1;
                n_cls.x = c;
                n_cls.y = mn;
                n_cls.z = mx;
                n_cls.off0 = OFF_P;
                n_cls.mag0 = i_pair_spin ? scte_pkg::MAG_H3 : scte_pkg::MAG_HALF;
                n_cls.neg0 = !pn;
                n_cls.mag1 = i_pair_spin ? scte_pkg::MAG_HALF : scte_pkg::MAG_H3;
                n_cls.neg1 = i_pair_spin ? !pn : pn;
            end else if (c == mn) begin
                n_cls.pair0 = 1'b1;
                n_cls.px = mn;
                n_cls.py = mx;
                n_cls.mag0 = i_pair_spin ? scte_pkg::MAG_H6 : scte_pkg::MAG_H2;
                n_cls.neg0 = !pn;
            end else if (c < mx) begin
                n_cls.two_terms = 1'b1;
                n_cls.x = mn;
                n_cls.y = c;
                n_cls.z = mx;
                n_cls.off0 = OFF_P;
                n_cls.mag0 = i_pair_spin ? scte_pkg::MAG_H3 : scte_pkg::MAG_HALF;
                n_cls.neg0 = !pn;
                n_cls.mag1 = i_pair_spin ? scte_pkg::MAG_HALF : scte_pkg::MAG_H3;
                n_cls.neg1 = i_pair_spin ? pn : !pn;
            end else begin
                n_cls.pair0 = 1'b1;
                n_cls.px = mx;
                n_cls.py = mn;
                n_cls.mag0 = i_pair_spin ? scte_pkg::MAG_H6 : scte_pkg::MAG_H2;
                n_cls.neg0 = i_pair_spin ? pn : !pn;
            end
        end else begin
            // sort the three distinct orbitals, sign from permutation parity
            n_cls.x = (gt_ab ? b : a) < c ? (gt_ab ? b : a) : c;
            n_cls.z = (gt_ab ? a : b) > c ? (gt_ab ? a : b) : c;
            if (gt_ab ^ gt_ac) begin
                n_cls.y = a;
            end else if (!gt_ab ^ gt_bc) begin
                n_cls.y = b;
            end else begin
                n_cls.y = c;
            end
            n_cls.neg0 = gt_ab ^ gt_bc ^ gt_ac;
        end
        if (inval) begin
            n_cls = '0;
            n_cls.off0 = OFF_NONE;
            n_cls.mag0 = scte_pkg::MAG_ZERO;
            n_cls.mag1 = scte_pkg::MAG_ZERO;
        end
    end

    assign o_ready = !r_v1 || !i_full;
    assign o_push  = r_v1 && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_ready) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cls <= n_cls;
        end
        r_pcount  <= n_pcount;
        r_ptcount <= n_ptcount;
    end

    // block offsets follow the orbital count; the user must change it only while idle, the block does not enforce this
    logic [NW-1:0] nm1;
    logic [TW-1:0] n7;
    assign nm1 = i_n - NW'(1);
    assign n7  = TW'(i_n);
    assign n_pcount  = XW'(QW'(i_n) * QW'(nm1));
    assign n_ptcount = n_pcount + scte_pkg::C3_TAB[n7];

    // index resolution on the classified item
    logic [TW-1:0] x7, y7;
    logic [XW-1:0] rank, pair_idx, off0_val;
    logic [PW-1:0] prod;
    logic [OW-1:0] adj;

    assign x7 = TW'(r_cls.x);
    assign y7 = TW'(r_cls.y);
    assign rank = scte_pkg::C3_TAB[n7] - scte_pkg::C3_TAB[n7 - x7]
                + scte_pkg::C2_TAB[n7 - x7 - TW'(1)] - scte_pkg::C2_TAB[n7 - y7]
                + XW'(r_cls.z) - XW'(r_cls.y) - XW'(1);
    assign prod = PW'(r_cls.px) * PW'(nm1);
    assign adj  = (r_cls.py < r_cls.px) ? r_cls.py : r_cls.py - OW'(1);
    assign pair_idx = XW'(prod) + XW'(adj);

    always_comb begin
        unique case (r_cls.off0)
            OFF_P:   off0_val = r_pcount;
            OFF_PT:  off0_val = r_ptcount;
            default: off0_val = '0;
        endcase
    end

    always_comb begin
        o_entry.two_terms  = r_cls.two_terms;
        o_entry.term_valid = r_cls.term_valid;
        o_entry.idx0 = !r_cls.term_valid ? '0 : (r_cls.pair0 ? pair_idx : rank + off0_val);
        o_entry.mag0 = r_cls.mag0;
        o_entry.neg0 = r_cls.neg0;
        o_entry.idx1 = rank + r_ptcount;
        o_entry.mag1 = r_cls.mag1;
        o_entry.neg1 = r_cls.neg1;
    end

endmodule

`default_nettype wire

### rtl/core/scte_queue.sv
// Short register queue that decouples the front end from the term emitter.
// Holds scte_pkg::t_qent entries. Uses scte_pkg.
`default_nettype none

module scte_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire scte_pkg::t_qent i_entry,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output scte_pkg::t_qent      o_head
);

    localparam int AW = scte_pkg::QUEUE_AW;

    scte_pkg::t_qent  r_mem [0:scte_pkg::QUEUE_DEPTH-1];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;

    assign o_full  = r_count == (AW+1)'(scte_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (AW+1)'(1);
                2'b01:   r_count <= r_count - (AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

### rtl/core/scte_back.sv
// Back end: walks the one or two terms of the queue head into the output
// register and turns coefficient codes into saturated fixed point. Uses scte_pkg.
`default_nettype none

module scte_back #(
    parameter int COEF_FRACTION_BITS = 14
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire scte_pkg::t_qent              i_head,
    input  wire logic                         i_empty,
    output logic                              o_pop,
    input  wire logic                         i_m_tready,
    output logic                              o_m_tvalid,
    output logic                              o_term_valid,
    output logic [scte_pkg::IDX_W-1:0]        o_index,
    output logic [scte_pkg::COEF_W-1:0]       o_coef,
    output logic                              o_last
);

    localparam int F = COEF_FRACTION_BITS;
    localparam logic [63:0] M_ONE  = 64'd1 << F;
    localparam logic [63:0] M_HALF = 64'd1 << (F - 1);
    localparam logic [63:0] M_H3   = scte_pkg::isqrt_round(64'd3 << (2 * F - 2));
    localparam logic [63:0] M_H2   = scte_pkg::isqrt_round(64'd1 << (2 * F - 1));
    localparam logic [63:0] M_H6   = scte_pkg::isqrt_round(64'd6 << (2 * F - 2));

    localparam logic [15:0] P_ONE  = scte_pkg::sat_coef(M_ONE, 1'b0);
    localparam logic [15:0] N_ONE  = scte_pkg::sat_coef(M_ONE, 1'b1);
    localparam logic [15:0] P_HALF = scte_pkg::sat_coef(M_HALF, 1'b0);
    localparam logic [15:0] N_HALF = scte_pkg::sat_coef(M_HALF, 1'b1);
    localparam logic [15:0] P_H3   = scte_pkg::sat_coef(M_H3, 1'b0);
    localparam logic [15:0] N_H3   = scte_pkg::sat_coef(M_H3, 1'b1);
    localparam logic [15:0] P_H2   = scte_pkg::sat_coef(M_H2, 1'b0);
    localparam logic [15:0] N_H2   = scte_pkg::sat_coef(M_H2, 1'b1);
    localparam logic [15:0] P_H6   = scte_pkg::sat_coef(M_H6, 1'b0);
    localparam logic [15:0] N_H6   = scte_pkg::sat_coef(M_H6, 1'b1);

    logic                          r_sel;
    logic                          r_valid;
    logic                          r_term_valid;
    logic [scte_pkg::IDX_W-1:0]    r_index;
    logic [scte_pkg::COEF_W-1:0]   r_coef;
    logic                          r_last;

    logic                          load, is_last, neg;
    scte_pkg::t_mag                mag;
    logic [scte_pkg::IDX_W-1:0]    idx;
    logic [scte_pkg::COEF_W-1:0]   coef;

    assign is_last = r_sel || !i_head.two_terms;
    assign load    = !i_empty && (!r_valid || i_m_tready);
    assign o_pop   = load && is_last;
    assign mag     = r_sel ? i_head.mag1 : i_head.mag0;
    assign neg     = r_sel ? i_head.neg1 : i_head.neg0;
    assign idx     = r_sel ? i_head.idx1 : i_head.idx0;

    always_comb begin
        unique case (mag)
            scte_pkg::MAG_ONE:  coef = neg ? N_ONE : P_ONE;
            scte_pkg::MAG_HALF: coef = neg ? N_HALF : P_HALF;
            scte_pkg::MAG_H3:   coef = neg ? N_H3 : P_H3;
            scte_pkg::MAG_H2:   coef = neg ? N_H2 : P_H2;
            scte_pkg::MAG_H6:   coef = neg ? N_H6 : P_H6;
            default:            coef = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sel   <= !is_last;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_term_valid <= i_head.term_valid;
            r_index      <= idx;
            r_coef       <= coef;
            r_last       <= is_last;
        end
    end

    assign o_m_tvalid   = r_valid;
    assign o_term_valid = r_term_valid;
    assign o_index      = r_index;
    assign o_coef       = r_coef;
    assign o_last       = r_last;

endmodule

`default_nettype wire

### sim/scte_tb_pkg.sv
// Stimulus codes shared by the expander testbench and its checker.
// No dependencies.
package scte_tb_pkg;

    localparam bit SPIN_HALF       = 1'b0;
    localparam bit SPIN_THREE_HALF = 1'b1;
    localparam bit PAIR_SINGLET    = 1'b0;
    localparam bit PAIR_TRIPLET    = 1'b1;

endpackage

### sim/scte_checker.sv
// Checker for the spin-coupled triple index expander: watches the configuration
// write and both streams, predicts each item's terms and compares them in order.
// Depends on scte_pkg and scte_tb_pkg.
module scte_checker #(
    parameter int MAX_ORBS  = 32,
    parameter int FRAC_BITS = 14
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [scte_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  logic                       i_s_tvalid,
    input  logic                       i_s_tready,
    input  logic [15:0]                i_s_tdata,
    input  logic [1:0]                 i_s_tuser,
    input  logic                       i_m_tvalid,
    input  logic                       i_m_tready,
    input  logic [31:0]                i_m_tdata,
    input  logic                       i_m_tuser,
    input  logic                       i_m_tlast,
    input  logic                       i_done,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_terms
);
    import scte_tb_pkg::*;

    typedef struct {
        logic        ok;
        logic [13:0] idx;
        logic [15:0] coef;
        logic        last;
    } t_term;

    function automatic longint root_round(longint v);
        longint r;
        longint t;
        r = 0;
        for (int k = 31; k >= 0; k--) begin
            t = r | (longint'(1) << k);
            if (t * t <= v) r = t;
        end
        if (v - r * r > r) r++;
        return r;
    endfunction

    localparam longint ONE_Q  = longint'(1) << FRAC_BITS;
    localparam longint HALF_Q = ONE_Q >> 1;
    localparam longint H3_Q   = root_round(longint'(3) << (2 * FRAC_BITS - 2));
    localparam longint H2_Q   = root_round(longint'(1) << (2 * FRAC_BITS - 1));
    localparam longint H6_Q   = root_round(longint'(6) << (2 * FRAC_BITS - 2));

    t_term                term_q[$];
    logic [scte_pkg::CFG_W-1:0] orbs_cfg = scte_pkg::CFG_RESET;
    int                   err_count = 0;
    int                   terms_checked = 0;
    int                   pending_q = 0;
    bit                   closed = 0;

    assign o_errors  = err_count;
    assign o_pending = pending_q;
    assign o_terms   = terms_checked;

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        err_count++;
        $display("MISMATCH at %0t: %s got %0h expected %0h", $time, field, got, want);
    endtask

    function automatic longint pairs_of(longint x);
        return x < 2 ? 0 : x * (x - 1) / 2;
    endfunction

    function automatic longint triples_of(longint x);
        return x < 3 ? 0 : x * (x - 1) * (x - 2) / 6;
    endfunction

    function automatic longint pair_slot(longint n, longint x, longint y);
        return x * (n - 1) + (y < x ? y : y - 1);
    endfunction

    // lexicographic rank of x<y<z among the triples of n orbitals
    function automatic longint triple_rank(longint n, longint x, longint y, longint z);
        return (triples_of(n) - triples_of(n - x)) + (pairs_of(n - x - 1) - pairs_of(n - y))
            + (z - y - 1);
    endfunction

    function automatic void add_term(bit ok, longint idx, longint coef, bit last);
        t_term t;
        if (coef > 32767) coef = 32767;
        if (coef < -32768) coef = -32768;
        t.ok   = ok;
        t.idx  = idx[13:0];
        t.coef = coef[15:0];
        t.last = last;
        term_q.push_back(t);
    endfunction

    function automatic void predict_expansion(bit blk, bit s, longint a, longint b, longint c,
                                              longint n);
        longint pc, tc, base, mn, mx, r, sg, x, y, z, t;
        int swaps;
        if (a >= n || b >= n || c >= n || (a == b && b == c)) begin
            add_term(0, 0, 0, 1);
        end else if (blk == SPIN_HALF) begin
            pc   = n * (n - 1);
            tc   = triples_of(n);
            base = pc + (s == PAIR_TRIPLET ? tc : 0);
            if (a == b) begin
                if (s == PAIR_TRIPLET) add_term(0, 0, 0, 1);
                else add_term(1, pair_slot(n, a, c), ONE_Q, 1);
            end else if (a < b && b < c) begin
                add_term(1, base + triple_rank(n, a, b, c), ONE_Q, 1);
            end else if (a > b && c > a) begin
                // swapped pair ahead of the third: phase only
                sg = (s == PAIR_TRIPLET) ? -1 : 1;
                add_term(1, base + triple_rank(n, b, a, c), sg * ONE_Q, 1);
            end else begin
                if (a < b) begin
                    mn = a; mx = b; sg = 1;
                end else begin
                    mn = b; mx = a; sg = (s == PAIR_TRIPLET) ? -1 : 1;
                end
                if (c < mn) begin
                    r = triple_rank(n, c, mn, mx);
                    add_term(1, pc + r, sg * (s ? -H3_Q : -HALF_Q), 0);
                    add_term(1, pc + tc + r, sg * (s ? -HALF_Q : H3_Q), 1);
                end else if (c == mn) begin
                    add_term(1, pair_slot(n, mn, mx), sg * (s ? -H6_Q : -H2_Q), 1);
                end else if (c < mx) begin
                    r = triple_rank(n, mn, c, mx);
                    add_term(1, pc + r, sg * (s ? -H3_Q : -HALF_Q), 0);
                    add_term(1, pc + tc + r, sg * (s ? HALF_Q : -H3_Q), 1);
                end else begin
                    add_term(1, pair_slot(n, mx, mn), sg * (s ? H6_Q : -H2_Q), 1);
                end
            end
        end else begin
            if (s == PAIR_SINGLET || a == b || b == c || a == c) begin
                add_term(0, 0, 0, 1);
            end else begin
                x = a; y = b; z = c; swaps = 0;
                if (x > y) begin t = x; x = y; y = t; swaps++; end
                if (y > z) begin t = y; y = z; z = t; swaps++; end
                if (x > y) begin t = x; x = y; y = t; swaps++; end
                add_term(1, triple_rank(n, x, y, z), swaps[0] ? -ONE_Q : ONE_Q, 1);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_term  want;
        longint n;
        if (!i_rst_n) begin
            orbs_cfg <= scte_pkg::CFG_RESET;
            term_q.delete();
            pending_q <= 0;
        end else begin
            if (i_cfg_wr_en) orbs_cfg <= i_cfg_wr_data;
            if (i_m_tvalid && i_m_tready) begin
                if (term_q.size() == 0) begin
                    report("term with nothing expected", i_m_tdata, 32'd0);
                end else begin
                    want = term_q.pop_front();
                    terms_checked++;
                    if (i_m_tuser !== want.ok) report("term_valid", i_m_tuser, want.ok);
                    if (i_m_tdata[13:0] !== want.idx)
                        report("basis_index", i_m_tdata[13:0], want.idx);
                    if (i_m_tdata[29:14] !== want.coef)
                        report("coefficient", i_m_tdata[29:14], want.coef);
                    if (i_m_tlast !== want.last) report("last_term", i_m_tlast, want.last);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                n = (orbs_cfg > MAX_ORBS) ? MAX_ORBS : orbs_cfg;
                predict_expansion(i_s_tuser[0], i_s_tuser[1], i_s_tdata[4:0],
                                  i_s_tdata[9:5], i_s_tdata[14:10], n);
            end
            if (i_done && !closed) begin
                closed <= 1'b1;
                if (term_q.size() != 0) report("terms never delivered", term_q.size(), 32'd0);
            end
            pending_q <= term_q.size();
        end
    end

endmodule

### sim/tb_top.sv
// Testbench top for the spin-coupled triple index expander: clock, reset,
// stimulus, orbital-count phases and verdict. Depends on scte_tb_pkg, scte_checker.
module tb_top;
    import scte_tb_pkg::*;

    localparam int PHASE_ITEMS = 305;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [5:0]  cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tready = 1'b1;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        run_done = 1'b0;

    int errors;
    int pending;
    int terms;
    int items_sent = 0;
    int settings_used = 0;
    int eff_orbs = 32;
    bit quiet = 0;

    spin_coupled_triple_index_expander_top u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .o_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .o_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .o_m_tdata     (m_tdata),
        .o_m_tuser     (m_tuser),
        .o_m_tlast     (m_tlast)
    );

    scte_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_m_tlast     (m_tlast),
        .i_done        (run_done),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_terms       (terms)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        #8000000;
        $display("Regression FAIL");
        $finish;
    end

    // sink stalls in bursts; none once the quiet phase starts
    initial begin
        forever begin
            repeat ($urandom_range(1, 30)) @(posedge clk);
            if (!quiet && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(bit blk, bit s, int a, int b, int c);
        s_tdata  <= {1'b0, 5'(c), 5'(b), 5'(a)};
        s_tuser  <= {s, blk};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    task automatic hold_off(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // hold input until every predicted term has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_orbitals(int v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= 6'(v);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        eff_orbs = (v > 32) ? 32 : v;
        settings_used++;
    endtask

    task automatic send_random();
        int pick;
        int hi_orb;
        int a, b, c;
        bit blk, s;
        pick   = $urandom_range(0, 9);
        hi_orb = eff_orbs - 1;
        blk    = 1'($urandom_range(0, 1));
        s      = 1'($urandom_range(0, 1));
        a      = $urandom_range(0, hi_orb);
        b      = $urandom_range(0, hi_orb);
        c      = $urandom_range(0, hi_orb);
        if (pick == 0) begin
            // noise: any orbital, any spin
            a = $urandom_range(0, 31);
            b = $urandom_range(0, 31);
            c = $urandom_range(0, 31);
        end else if (blk == SPIN_THREE_HALF) begin
            s = ($urandom_range(0, 9) != 0) ? PAIR_TRIPLET : PAIR_SINGLET;
        end else if (pick <= 2) begin
            b = a;
            s = ($urandom_range(0, 4) != 0) ? PAIR_SINGLET : PAIR_TRIPLET;
        end
        if (!quiet && $urandom_range(0, 7) == 0) hold_off($urandom_range(1, 14));
        send_item(blk, s, a, b, c);
    endtask

    initial begin
        int orbs [6];
        int spin;
        orbs = '{3, 63, 2, 17, 32, 0};
        @(posedge clk);
        while (!rst_n) @(posedge clk);

        // directed: every ordering branch at the reset orbital count
        send_item(SPIN_HALF, PAIR_SINGLET, 5, 5, 9);
        send_item(SPIN_HALF, PAIR_SINGLET, 31, 31, 0);
        send_item(SPIN_HALF, PAIR_TRIPLET, 4, 4, 7);
        send_item(SPIN_HALF, PAIR_SINGLET, 0, 1, 2);
        send_item(SPIN_HALF, PAIR_TRIPLET, 29, 30, 31);
        send_item(SPIN_HALF, PAIR_SINGLET, 10, 3, 20);
        send_item(SPIN_HALF, PAIR_TRIPLET, 10, 3, 20);
        send_item(SPIN_HALF, PAIR_SINGLET, 5, 9, 2);
        send_item(SPIN_HALF, PAIR_TRIPLET, 9, 5, 2);
        send_item(SPIN_HALF, PAIR_SINGLET, 5, 9, 5);
        send_item(SPIN_HALF, PAIR_TRIPLET, 9, 5, 5);
        send_item(SPIN_HALF, PAIR_SINGLET, 5, 9, 7);
        send_item(SPIN_HALF, PAIR_TRIPLET, 9, 5, 7);
        send_item(SPIN_HALF, PAIR_SINGLET, 5, 9, 9);
        send_item(SPIN_HALF, PAIR_TRIPLET, 9, 5, 9);
        send_item(SPIN_HALF, PAIR_SINGLET, 31, 0, 31);
        send_item(SPIN_HALF, PAIR_SINGLET, 7, 7, 7);
        send_item(SPIN_THREE_HALF, PAIR_SINGLET, 1, 2, 3);
        send_item(SPIN_THREE_HALF, PAIR_TRIPLET, 4, 4, 8);
        send_item(SPIN_THREE_HALF, PAIR_TRIPLET, 2, 8, 8);
        send_item(SPIN_THREE_HALF, PAIR_TRIPLET, 8, 2, 8);
        send_item(SPIN_THREE_HALF, PAIR_TRIPLET, 0, 15, 31);
        send_item(SPIN_THREE_HALF, PAIR_TRIPLET, 15, 0, 31);
        send_item(SPIN_THREE_HALF, PAIR_TRIPLET, 31, 15, 0);
        send_item(SPIN_THREE_HALF, PAIR_TRIPLET, 15, 31, 0);

        for (int p = 0; p < 6; p++) begin
            if (p == 5) begin
                quiet = 1;
                orbs[p] = $urandom_range(3, 31);
            end
            set_orbitals(orbs[p]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 1 && i == PHASE_ITEMS / 2) drain();
                send_random();
            end
        end

        s_tvalid <= 1'b0;
        spin = 0;
        @(posedge clk);
        while (pending != 0 && spin < 5000) begin
            @(posedge clk);
            spin++;
        end
        repeat (10) @(posedge clk);
        run_done <= 1'b1;
        repeat (2) @(posedge clk);

        $display("Sent %0d items across %0d orbital-count settings, including 2, 3, 32 and 63",
                 items_sent, settings_used);
        $display("Compared %0d terms with the predicted expansion", terms);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
